// ===== src/tre_pkg.sv =====
`timescale 1ns / 1ps

package tre_pkg;

    localparam int GRAY_W      = 8;
    localparam int WIDTH_REG_W = 13;
    localparam int THRESH_W    = 9;
    localparam int COL_FIELD_W = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = WIDTH_REG_W;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [THRESH_W-1:0]    THRESH_RESET = 9'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH = 1'b0,
        CFG_THRESHOLD   = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic                   has_run;
        logic [COL_FIELD_W-1:0] run_start;
        logic [COL_FIELD_W-1:0] run_end;
        logic                   row_done;
    } t_result;

endpackage

// ===== src/threshold_run_encoder_core.sv =====
`timescale 1ns / 1ps

// Binary run-length encoder for a raster-order grayscale pixel stream.
// Slave stream: one 8-bit pixel per transfer in tdata. A pixel below the
// threshold register is dark. Master stream: one transfer per closed dark
// run or row end. tdata carries run start and run end columns (inclusive),
// tuser flags that a run is reported, tlast marks the last pixel of a row.
// A run still open at the row end is closed there.
// Config: image_width (index 0) and threshold (index 1), written through the
// write-enable port while no pixel is in flight; used from the next pixel.
// A result is registered and presented in the cycle after its pixel transfer.
// Throughput: one pixel per cycle while the output slot is free or draining;
// the column compare and counter update sit between the input transfer and the output register.
// Reset: column zero, no run open, output empty, width 640, threshold 128.
// Stall: while a result waits on m_axis_tready the input is held off;
// pixels that produce no result still flow only when the output slot is
// free or draining in the same cycle.
module threshold_run_encoder_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] gray_level
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [23:0]                         m_axis_tdata,  // [11:0] run_start, [23:12] run_end
    output logic                                m_axis_tuser,  // [0] has_run
    output logic                                m_axis_tlast,  // row_done
    input  logic                                i_cfg_we,
    input  logic [tre_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tre_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [tre_pkg::WIDTH_REG_W-1:0] r_image_width;
    logic [tre_pkg::THRESH_W-1:0]    r_threshold;
    logic [CW-1:0]                   r_column;
    logic                            r_run_open;
    logic [CW-1:0]                   r_open_start;
    logic                            r_out_valid;
    tre_pkg::t_result                r_result;

    logic [CW-1:0]    n_column;
    logic             n_run_open;
    logic [CW-1:0]    n_open_start;
    logic             step_emit;
    tre_pkg::t_result step_result;
    logic             in_xfer;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    tre_step #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_step (
        .i_gray        (s_axis_tdata[tre_pkg::GRAY_W-1:0]),
        .i_image_width (r_image_width),
        .i_threshold   (r_threshold),
        .i_column      (r_column),
        .i_run_open    (r_run_open),
        .i_open_start  (r_open_start),
        .o_column      (n_column),
        .o_run_open    (n_run_open),
        .o_open_start  (n_open_start),
        .o_emit        (step_emit),
        .o_result      (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= tre_pkg::WIDTH_RESET;
            r_threshold   <= tre_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            case (tre_pkg::t_cfg_index'(i_cfg_index))
                tre_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[tre_pkg::WIDTH_REG_W-1:0];
                end
                tre_pkg::CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[tre_pkg::THRESH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_run_open   <= 1'b0;
            r_open_start <= '0;
        end else if (in_xfer) begin
            r_column     <= n_column;
            r_run_open   <= n_run_open;
            r_open_start <= n_open_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= in_xfer && step_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && step_emit) begin
            r_result <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_result.run_end, r_result.run_start};
    assign m_axis_tuser  = r_result.has_run;
    assign m_axis_tlast  = r_result.row_done;

    a_result_meaningful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
        else $error("result with neither run nor row end");

    a_open_run_behind_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_open |-> (r_open_start < r_column))
        else $error("open run start not behind column");

    a_no_input_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !in_xfer)
        else $error("pixel taken while result stalled");

    a_result_follows_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && step_emit) |=> m_axis_tvalid)
        else $error("emitted result not presented");

endmodule

// ===== src/tre_step.sv =====
`timescale 1ns / 1ps

module tre_step #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic [tre_pkg::GRAY_W-1:0]      i_gray,
    input  logic [tre_pkg::WIDTH_REG_W-1:0] i_image_width,
    input  logic [tre_pkg::THRESH_W-1:0]    i_threshold,
    input  logic [$clog2(MAX_WIDTH)-1:0]    i_column,
    input  logic                            i_run_open,
    input  logic [$clog2(MAX_WIDTH)-1:0]    i_open_start,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_column,
    output logic                            o_run_open,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_open_start,
    output logic                            o_emit,
    output tre_pkg::t_result                o_result
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = ((CW > tre_pkg::WIDTH_REG_W) ? CW : tre_pkg::WIDTH_REG_W) + 1;
    localparam int XW   = (CW > tre_pkg::COL_FIELD_W) ? CW : tre_pkg::COL_FIELD_W;

    logic [CMPW-1:0] width_x;
    logic [CMPW-1:0] last_col;
    logic            dark;
    logic            last;
    logic            has_run;
    logic [CW-1:0]   start_col;
    logic [CW-1:0]   end_col;
    logic [XW-1:0]   start_x;
    logic [XW-1:0]   end_x;

    // effective width: zero counts as one, saturates at MAX_WIDTH
    always_comb begin
        width_x = CMPW'(i_image_width);
        if (width_x == '0) begin
            last_col = '0;
        end else if (width_x > CMPW'(MAX_WIDTH)) begin
            last_col = CMPW'(MAX_WIDTH - 1);
        end else begin
            last_col = width_x - CMPW'(1);
        end
    end

    assign dark = {1'b0, i_gray} < i_threshold;
    assign last = CMPW'(i_column) >= last_col;

    always_comb begin
        o_open_start = i_open_start;
        start_col    = i_open_start;
        end_col      = i_column;
        has_run      = 1'b0;
        if (dark) begin
            if (!i_run_open) begin
                o_open_start = i_column;
                start_col    = i_column;
            end
            has_run = last;
        end else if (i_run_open) begin
            has_run = 1'b1;
            end_col = i_column - CW'(1);
        end
    end

    assign o_run_open = (dark || i_run_open) && !(has_run || last);
    assign o_column   = last ? '0 : i_column + CW'(1);
    assign o_emit     = has_run || last;

    assign start_x = XW'(start_col);
    assign end_x   = XW'(end_col);

    always_comb begin
        o_result.has_run   = has_run;
        o_result.run_start = has_run ? start_x[tre_pkg::COL_FIELD_W-1:0] : '0;
        o_result.run_end   = has_run ? end_x[tre_pkg::COL_FIELD_W-1:0] : '0;
        o_result.row_done  = last;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_WIDTH    = 4096;
    localparam int PIXEL_TARGET = 1800;
    localparam int NUM_DIRECTED = 29;

    typedef enum logic [1:0] {
        STEP_PIXEL,
        STEP_SET_WIDTH,
        STEP_SET_THRESH
    } t_step_kind;

    typedef struct {
        t_step_kind       kind;
        logic [12:0]      value;
        bit               fixed;
        bit               yields;
        tre_pkg::t_result res;
    } t_step;

    typedef struct {
        bit               fixed;
        bit               yields;
        tre_pkg::t_result res;
    } t_pixel_note;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic [7:0]                     s_axis_tdata  = '0;
    logic                           m_axis_tready = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [tre_pkg::CFG_IDX_W-1:0]  i_cfg_index   = tre_pkg::CFG_IMAGE_WIDTH;
    logic [tre_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                           s_axis_tready;
    logic                           m_axis_tvalid;
    logic [23:0]                    m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           m_axis_tlast;

    // encoder state as predicted
    int unsigned width_reg  = 640;
    int unsigned thresh_reg = 128;
    int unsigned col_pos    = 0;
    bit          run_active = 1'b0;
    int unsigned run_first  = 0;

    tre_pkg::t_result expected_runs [$];
    t_pixel_note      pixel_notes [$];
    int               mismatch_count = 0;
    int               src_idle   = 0;
    int               sink_stall = 0;

    // fixed rows: {has_run, run_start, run_end, row_done}
    t_step directed [NUM_DIRECTED] = '{
        '{STEP_PIXEL,      13'd0,     1'b1, 1'b0, tre_pkg::t_result'{1'b0, 12'd0, 12'd0, 1'b0}},
        '{STEP_PIXEL,      13'd255,   1'b1, 1'b1, tre_pkg::t_result'{1'b1, 12'd0, 12'd0, 1'b0}},
        '{STEP_PIXEL,      13'd127,   1'b1, 1'b0, tre_pkg::t_result'{1'b0, 12'd0, 12'd0, 1'b0}},
        '{STEP_PIXEL,      13'd128,   1'b1, 1'b1, tre_pkg::t_result'{1'b1, 12'd2, 12'd2, 1'b0}},
        '{STEP_SET_WIDTH,  13'd4,     1'b0, 1'b0, '0},
        '{STEP_PIXEL,      13'd255,   1'b1, 1'b1, tre_pkg::t_result'{1'b0, 12'd0, 12'd0, 1'b1}},
        '{STEP_PIXEL,      13'd0,     1'b1, 1'b0, tre_pkg::t_result'{1'b0, 12'd0, 12'd0, 1'b0}},
        '{STEP_PIXEL,      13'd0,     1'b1, 1'b0, tre_pkg::t_result'{1'b0, 12'd0, 12'd0, 1'b0}},
        '{STEP_PIXEL,      13'd0,     1'b1, 1'b0, tre_pkg::t_result'{1'b0, 12'd0, 12'd0, 1'b0}},
        '{STEP_PIXEL,      13'd0,     1'b1, 1'b1, tre_pkg::t_result'{1'b1, 12'd0, 12'd3, 1'b1}},
        '{STEP_PIXEL,      13'd255,   1'b1, 1'b0, tre_pkg::t_result'{1'b0, 12'd0, 12'd0, 1'b0}},
        '{STEP_PIXEL,      13'd0,     1'b1, 1'b0, tre_pkg::t_result'{1'b0, 12'd0, 12'd0, 1'b0}},
        '{STEP_PIXEL,      13'd0,     1'b1, 1'b0, tre_pkg::t_result'{1'b0, 12'd0, 12'd0, 1'b0}},
        '{STEP_PIXEL,      13'd255,   1'b1, 1'b1, tre_pkg::t_result'{1'b1, 12'd1, 12'd2, 1'b1}},
        '{STEP_SET_WIDTH,  13'd0,     1'b0, 1'b0, '0},
        '{STEP_PIXEL,      13'd0,     1'b1, 1'b1, tre_pkg::t_result'{1'b1, 12'd0, 12'd0, 1'b1}},
        '{STEP_PIXEL,      13'd255,   1'b1, 1'b1, tre_pkg::t_result'{1'b0, 12'd0, 12'd0, 1'b1}},
        '{STEP_SET_THRESH, 13'd0,     1'b0, 1'b0, '0},
        '{STEP_PIXEL,      13'd0,     1'b1, 1'b1, tre_pkg::t_result'{1'b0, 12'd0, 12'd0, 1'b1}},
        '{STEP_SET_THRESH, 13'h1F00,  1'b0, 1'b0, '0},
        '{STEP_PIXEL,      13'd255,   1'b1, 1'b1, tre_pkg::t_result'{1'b1, 12'd0, 12'd0, 1'b1}},
        '{STEP_SET_WIDTH,  13'd8191,  1'b0, 1'b0, '0},
        '{STEP_PIXEL,      13'd200,   1'b0, 1'b0, '0},
        '{STEP_PIXEL,      13'd17,    1'b0, 1'b0, '0},
        '{STEP_SET_THRESH, 13'd128,   1'b0, 1'b0, '0},
        '{STEP_PIXEL,      13'd200,   1'b0, 1'b0, '0},
        '{STEP_PIXEL,      13'd90,    1'b0, 1'b0, '0},
        '{STEP_SET_WIDTH,  13'd3,     1'b0, 1'b0, '0},
        '{STEP_PIXEL,      13'd60,    1'b0, 1'b0, '0}
    };

    threshold_run_encoder_core #(
        .MAX_WIDTH(MAX_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned row_width();
        int unsigned w;
        w = (width_reg == 0) ? 1 : width_reg;
        if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        return w;
    endfunction

    // advances the encoder state by one pixel; returns 1 when a transfer is due
    function automatic bit encode_pixel(input logic [7:0] gray, output tre_pkg::t_result res);
        bit          dark;
        bit          at_end;
        bit          closed;
        int unsigned first_col;
        int unsigned last_col;
        dark      = gray < thresh_reg;
        at_end    = col_pos >= row_width() - 1;
        closed    = 1'b0;
        first_col = 0;
        last_col  = 0;
        if (dark) begin
            if (!run_active) begin
                run_active = 1'b1;
                run_first  = col_pos;
            end
            if (at_end) begin
                closed    = 1'b1;
                first_col = run_first;
                last_col  = col_pos;
            end
        end else if (run_active) begin
            closed    = 1'b1;
            first_col = run_first;
            last_col  = col_pos - 1;
        end
        if (closed || at_end) begin
            run_active = 1'b0;
        end
        col_pos = at_end ? 0 : col_pos + 1;
        res.has_run   = closed;
        res.run_start = closed ? first_col[11:0] : '0;
        res.run_end   = closed ? last_col[11:0] : '0;
        res.row_done  = at_end;
        return closed || at_end;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= (sink_stall == 0) || ($urandom_range(0, 99) >= sink_stall);
    end

    always @(posedge i_clk) begin
        t_pixel_note      note;
        tre_pkg::t_result res;
        tre_pkg::t_result want;
        bit               yields;
        if (!i_rst_n) begin
            width_reg  = 640;
            thresh_reg = 128;
            col_pos    = 0;
            run_active = 1'b0;
            run_first  = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == tre_pkg::CFG_IMAGE_WIDTH) begin
                    width_reg = i_cfg_data;
                end else begin
                    thresh_reg = i_cfg_data[tre_pkg::THRESH_W-1:0];
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                note   = pixel_notes.pop_front();
                yields = encode_pixel(s_axis_tdata, res);
                if (note.fixed) begin
                    yields = note.yields;
                    res    = note.res;
                end
                if (yields) begin
                    expected_runs.push_back(res);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_runs.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual %0d %0d %0d %0d",
                             $time, m_axis_tuser, m_axis_tdata[11:0], m_axis_tdata[23:12],
                             m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_runs.pop_front();
                    check_field("has_run", want.has_run, m_axis_tuser);
                    check_field("run_start", want.run_start, m_axis_tdata[11:0]);
                    check_field("run_end", want.run_end, m_axis_tdata[23:12]);
                    check_field("row_done", want.row_done, m_axis_tlast);
                end
            end
        end
    end

    task automatic set_mode(input int mode);
        case (mode)
            0: begin
                src_idle   = 0;
                sink_stall = 0;
            end
            1: begin
                src_idle   = 84;
                sink_stall = 0;
            end
            2: begin
                src_idle   = 0;
                sink_stall = 84;
            end
            default: begin
                src_idle   = 20;
                sink_stall = 20;
            end
        endcase
    endtask

    task automatic send_pixel(input logic [7:0] gray, input bit fixed, input bit yields,
                              input tre_pkg::t_result res);
        t_pixel_note note;
        while (src_idle != 0 && $urandom_range(0, 99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        note.fixed  = fixed;
        note.yields = yields;
        note.res    = res;
        pixel_notes.push_back(note);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= gray;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold off the source until every pending result has drained
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_runs.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input tre_pkg::t_cfg_index idx,
                             input logic [tre_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pick_gray(input bit want_dark);
        int unsigned lim;
        lim = (thresh_reg > 256) ? 256 : thresh_reg;
        if (want_dark && lim > 0) begin
            return ($urandom_range(0, 7) == 0) ? 8'(lim - 1) : 8'($urandom_range(0, lim - 1));
        end
        if (!want_dark && lim <= 255) begin
            return ($urandom_range(0, 7) == 0) ? 8'(lim) : 8'($urandom_range(lim, 255));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // alternating dark and bright spans, with some plain noise mixed in
    task automatic run_phase(input int count);
        int          n;
        int          span;
        int unsigned span_max;
        bit          dark_span;
        logic [7:0]  gray;
        n         = 0;
        dark_span = 1'($urandom_range(0, 1));
        span_max  = (row_width() < 48) ? row_width() : 48;
        while (n < count) begin
            span = int'($urandom_range(1, span_max));
            for (int i = 0; i < span && n < count; i++) begin
                gray = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                   : pick_gray(dark_span);
                send_pixel(gray, 1'b0, 1'b0, '0);
                n++;
            end
            dark_span = !dark_span;
        end
    endtask

    initial begin
        int          phase;
        int          sent;
        int          count;
        int unsigned pick;
        logic [tre_pkg::CFG_DATA_W-1:0] value;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_mode(3);
        foreach (directed[k]) begin
            case (directed[k].kind)
                STEP_PIXEL: begin
                    send_pixel(directed[k].value[7:0], directed[k].fixed, directed[k].yields,
                               directed[k].res);
                end
                STEP_SET_WIDTH: begin
                    settle();
                    write_reg(tre_pkg::CFG_IMAGE_WIDTH, directed[k].value);
                end
                default: begin
                    settle();
                    write_reg(tre_pkg::CFG_THRESHOLD, directed[k].value);
                end
            endcase
        end
        sent  = 0;
        phase = 0;
        while (sent < PIXEL_TARGET) begin
            settle();
            if ($urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    value = 0;
                end else if (pick == 1) begin
                    value = 1;
                end else if (pick == 2) begin
                    value = tre_pkg::CFG_DATA_W'($urandom_range(0, 8191));
                end else if (pick < 13) begin
                    value = tre_pkg::CFG_DATA_W'($urandom_range(2, 16));
                end else if (pick < 18) begin
                    value = tre_pkg::CFG_DATA_W'($urandom_range(17, 100));
                end else begin
                    value = tre_pkg::CFG_DATA_W'($urandom_range(101, 700));
                end
                write_reg(tre_pkg::CFG_IMAGE_WIDTH, value);
            end
            if ($urandom_range(0, 2) != 0) begin
                pick = $urandom_range(0, 15);
                case (pick)
                    0:       value = 0;
                    1:       value = 256;
                    2:       value = tre_pkg::CFG_DATA_W'($urandom_range(0, 8191));
                    3:       value = 255;
                    4:       value = 1;
                    default: value = tre_pkg::CFG_DATA_W'($urandom_range(1, 255));
                endcase
                write_reg(tre_pkg::CFG_THRESHOLD, value);
            end
            set_mode(phase % 4);
            count = int'($urandom_range(20, 100));
            run_phase(count);
            sent += count;
            phase++;
        end
        settle();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
